FILE: rtl/ppa_pkg.sv
// Shared types and constants of the phased PWM audio pattern block.
`timescale 1ns / 1ps
package ppa_pkg;

  localparam int unsigned ENTRY_W = 13;
  localparam int unsigned PINS    = 64;   // 4 ports x 16 pins
  localparam int unsigned CNT_W   = 8;

  localparam logic [7:0] REG_GAIN = 8'd0;
  localparam logic [7:0] REG_LED  = 8'd1;

  localparam logic [15:0] GAIN_RESET = 16'd32768;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [7:0]         entry_index;
    logic               entry_enable;
    logic [1:0]         entry_port;
    logic [3:0]         entry_pin;
    logic [5:0]         entry_phase;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  tick;
    logic [15:0] port0_word;
    logic [15:0] port1_word;
    logic [15:0] port2_word;
    logic [15:0] port3_word;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_Q1, ST_Q2, ST_Q3, ST_CLR, ST_ERD, ST_EMAP, ST_EWR,
    ST_PRD, ST_PUPD, ST_ORD, ST_OUPD, ST_OWAIT
  } state_t;

  typedef struct packed {
    logic load_tbl;
    logic take_sample;
    logic q1;
    logic q2;
    logic q3;
    logic clr;
    logic e_rd;
    logic e_map;
    logic e_wr;
    logic idx_inc;
    logic t_rd;
    logic t_pre;
    logic t_upd;
    logic out_load;
    logic tick_clr;
    logic tick_inc;
  } cmd_t;

  typedef struct packed {
    logic e_last;
    logic t_last;
    logic out_fire;
  } sts_t;

endpackage

FILE: rtl/ppa_ctrl.sv
// Sequencer: quantize, clear edge rows, walk the table, prime counts, emit ticks.
`timescale 1ns / 1ps
module ppa_ctrl
  import ppa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  input  sts_t     sts,
  output cmd_t     cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) cmd.load_tbl = 1'b1;
          else begin
            cmd.take_sample = 1'b1;
            state_nxt = ST_Q1;
          end
        end
      end
      ST_Q1: begin cmd.q1 = 1'b1; state_nxt = ST_Q2; end
      ST_Q2: begin cmd.q2 = 1'b1; state_nxt = ST_Q3; end
      ST_Q3: begin cmd.q3 = 1'b1; state_nxt = ST_CLR; end
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.t_last) begin
          cmd.tick_clr = 1'b1;
          state_nxt = ST_ERD;
        end else cmd.tick_inc = 1'b1;
      end
      ST_ERD:  begin cmd.e_rd = 1'b1; state_nxt = ST_EMAP; end
      ST_EMAP: begin cmd.e_map = 1'b1; state_nxt = ST_EWR; end
      ST_EWR: begin
        cmd.e_wr = 1'b1;
        if (sts.e_last) state_nxt = ST_PRD;
        else begin
          cmd.idx_inc = 1'b1;
          state_nxt = ST_ERD;
        end
      end
      // first pass over the period counts the intervals wrapping into tick 0
      ST_PRD: begin cmd.t_rd = 1'b1; state_nxt = ST_PUPD; end
      ST_PUPD: begin
        cmd.t_pre = 1'b1;
        if (sts.t_last) begin
          cmd.tick_clr = 1'b1;
          state_nxt = ST_ORD;
        end else begin
          cmd.tick_inc = 1'b1;
          state_nxt = ST_PRD;
        end
      end
      ST_ORD: begin cmd.t_rd = 1'b1; state_nxt = ST_OUPD; end
      ST_OUPD: begin
        cmd.t_upd    = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt    = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (sts.out_fire) begin
          if (sts.t_last) state_nxt = ST_IDLE;
          else begin
            cmd.tick_inc = 1'b1;
            state_nxt = ST_ORD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/ppa_dp.sv
// Datapath: quantizer, transducer table, edge event rows, pin counters, output register.
`timescale 1ns / 1ps
module ppa_dp
  import ppa_pkg::*;
#(
  parameter int unsigned PERIOD_TICKS = 50,
  parameter int unsigned PORTS        = 4,
  parameter int unsigned TRANSDUCERS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int unsigned IW   = (TRANSDUCERS > 1) ? $clog2(TRANSDUCERS) : 1;
  localparam int unsigned HALF = PERIOD_TICKS / 2;
  localparam logic [27:0] TOP  = 28'(HALF * 65536);

  // configuration
  logic [15:0] gain_r, led_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      led_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_GAIN) gain_r <= cfg_data;
      if (cfg_index == REG_LED)  led_r  <= cfg_data;
    end
  end

  // transducer table with per-entry valid bits
  logic [ENTRY_W-1:0] tbl_mem [TRANSDUCERS];
  logic [TRANSDUCERS-1:0] tbl_vld_r;
  logic [ENTRY_W-1:0] tbl_q_r;
  logic               tbl_qv_r;
  logic [IW-1:0]      idx_r;
  logic               load_ok;
  logic [IW-1:0]      load_idx;

  assign load_ok  = ({1'b0, in_data.entry_index} < 9'(TRANSDUCERS));
  assign load_idx = IW'(in_data.entry_index);

  always_ff @(posedge clk) begin
    if (cmd.load_tbl && load_ok)
      tbl_mem[load_idx] <= {in_data.entry_enable, in_data.entry_port,
                            in_data.entry_pin, in_data.entry_phase};
    if (cmd.e_rd) tbl_q_r <= tbl_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      tbl_qv_r  <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cmd.load_tbl && load_ok) tbl_vld_r[load_idx] <= 1'b1;
      if (cmd.e_rd) tbl_qv_r <= tbl_vld_r[idx_r];
      if (cmd.take_sample)  idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  // error-feedback quantizer
  logic signed [15:0] samp_r;
  logic signed [32:0] m_r;
  logic signed [39:0] p_r;
  logic [5:0]         duty_r;
  logic [15:0]        ce_r;
  logic signed [27:0] qsum;
  logic [27:0]        qclamp;

  assign qsum = $signed(TOP) + 28'($signed(p_r[39:14])) + $signed({12'd0, ce_r});

  always_comb begin
    if (qsum < 0)                    qclamp = '0;
    else if ($unsigned(qsum) > TOP)  qclamp = TOP;
    else                             qclamp = $unsigned(qsum);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) samp_r <= in_data.sample;
    if (cmd.q1) m_r <= samp_r * $signed({1'b0, gain_r});
    if (cmd.q2) p_r <= 40'(m_r) * $signed(40'(HALF));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_r   <= '0;
      duty_r <= '0;
    end else if (cmd.q3) begin
      ce_r   <= qclamp[15:0];
      duty_r <= qclamp[21:16];
    end
  end

  // per-entry edge mapping
  logic [ENTRY_W-1:0] ent;
  logic [5:0]         ph_m, start, endp;
  logic [6:0]         end_sum;
  logic               act;
  logic [5:0]         tick_r, start_r, end_r;
  logic [PINS-1:0]    bit_r;

  assign ent     = tbl_qv_r ? tbl_q_r : '0;
  assign ph_m    = (ent[5:0] >= 6'(PERIOD_TICKS)) ? ent[5:0] - 6'(PERIOD_TICKS) : ent[5:0];
  assign start   = (ph_m == '0) ? '0 : 6'(PERIOD_TICKS) - ph_m;
  assign end_sum = {1'b0, start} + {1'b0, duty_r};
  assign endp    = (end_sum >= 7'(PERIOD_TICKS)) ? 6'(end_sum - 7'(PERIOD_TICKS))
                                                 : end_sum[5:0];
  assign act     = ent[12] && ({1'b0, ent[11:10]} < 3'(PORTS));

  always_ff @(posedge clk) begin
    if (cmd.e_map) begin
      start_r <= start;
      end_r   <= endp;
      bit_r   <= act ? (PINS'(1) << {ent[11:10], ent[9:6]}) : '0;
    end
  end

  // edge rows: rising and falling pin masks per tick
  logic [PINS-1:0] rise_mem [PERIOD_TICKS];
  logic [PINS-1:0] fall_mem [PERIOD_TICKS];
  logic [PINS-1:0] rise_q_r, fall_q_r;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      rise_mem[tick_r] <= '0;
      fall_mem[tick_r] <= '0;
    end else if (cmd.e_wr) begin
      rise_mem[start_r] <= rise_q_r | bit_r;
      fall_mem[end_r]   <= fall_q_r | bit_r;
    end
    if (cmd.e_map) begin
      rise_q_r <= rise_mem[start];
      fall_q_r <= fall_mem[endp];
    end else if (cmd.t_rd) begin
      rise_q_r <= rise_mem[tick_r];
      fall_q_r <= fall_mem[tick_r];
    end
  end

  // tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) tick_r <= '0;
    else if (cmd.take_sample || cmd.tick_clr) tick_r <= '0;
    else if (cmd.tick_inc) tick_r <= tick_r + 1'b1;
  end

  // active interval count per pin
  logic signed [CNT_W-1:0] cnt_r   [PINS];
  logic signed [CNT_W-1:0] cnt_nxt [PINS];
  logic [PINS-1:0]         on;
  logic                    wrap_t;

  // a rise at this tick belongs to an interval that runs past the period end
  assign wrap_t = (duty_r != '0) &&
                  (({1'b0, tick_r} + {1'b0, duty_r}) >= 7'(PERIOD_TICKS));

  always_comb begin
    for (int i = 0; i < PINS; i++) begin
      cnt_nxt[i] = cnt_r[i] + $signed({{(CNT_W-1){1'b0}}, rise_q_r[i]})
                            - $signed({{(CNT_W-1){1'b0}}, fall_q_r[i]});
      on[i] = (cnt_nxt[i] > 0);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PINS; i++) begin
      if (cmd.take_sample) cnt_r[i] <= '0;
      else if (cmd.t_pre)
        cnt_r[i] <= cnt_r[i] + $signed({{(CNT_W-1){1'b0}}, rise_q_r[i] & wrap_t});
      else if (cmd.t_upd)  cnt_r[i] <= cnt_nxt[i];
    end
  end

  // output register
  logic out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.tick       <= tick_r;
      out_r.port0_word <= on[15:0] | led_r;
      out_r.port1_word <= on[31:16];
      out_r.port2_word <= on[47:32];
      out_r.port3_word <= on[63:48];
      out_r.last       <= (tick_r == 6'(PERIOD_TICKS - 1));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.e_last   = (idx_r == IW'(TRANSDUCERS - 1));
  assign sts.t_last   = (tick_r == 6'(PERIOD_TICKS - 1));
  assign sts.out_fire = out_valid_r && out_ready;

endmodule

FILE: rtl/phased_pwm_audio_pattern.sv
// Phase-shifted multichannel PWM pattern generator, top level.
// Input channel (in_valid/in_ready, in_data): a load request writes one
//   transducer table entry; a sample request quantizes the
//   audio sample to a duty and produces PERIOD_TICKS result requests.
// Result channel (out_valid/out_ready, out_data): one request per tick, with
//   the four port words and a last flag on the final tick.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 is gain, index 1 is the LED overlay. Write only while idle.
// Steps of a sample: quantizer, clearing the edge rows, then per table entry
//   a read, an edge row read and an edge row write, then a pass over the
//   period to settle the wrapped pin counts, then per emitted tick a read,
//   a pin count update and output load, and a wait for the result to be taken.
// One request is worked on at a time; in_ready is high only when idle.
// A stalled receiver holds the sequencer until the pending result is taken.
// Reset clears the table valid bits, carried error, gain to unity and
//   the LED overlay to zero; the block is ready in the cycle after reset.
`timescale 1ns / 1ps
module phased_pwm_audio_pattern
  import ppa_pkg::*;
#(
  parameter int unsigned PERIOD_TICKS = 50,
  parameter int unsigned PORTS        = 4,
  parameter int unsigned TRANSDUCERS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ppa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppa_dp #(
    .PERIOD_TICKS (PERIOD_TICKS),
    .PORTS        (PORTS),
    .TRANSDUCERS  (TRANSDUCERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
